### hw/rtl/cpr_pkg.sv
// Shared types and constants for the clock page replacer.
package cpr_pkg;

  localparam int FRAME_SLOTS = 64;
  localparam int FRAME_W     = 6;
  localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
  localparam int STEP_W      = CNT_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_SLOTS);

  typedef enum logic [1:0] {
    KIND_VICTIM = 2'd0,
    KIND_PIN    = 2'd1,
    KIND_UNPIN  = 2'd2,
    KIND_ACCESS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_VICTIM,
    OP_PIN,
    OP_UNPIN,
    OP_ACCESS
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] frame;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

### hw/rtl/cpr_front.sv
// Front end: frame count register, command decode and command queue.
module cpr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cpr_pkg::in_item_t           in_data,
  input  logic                        cfg_we,
  input  logic [cpr_pkg::CNT_W-1:0]   cfg_wdata,
  output logic [cpr_pkg::CNT_W-1:0]   active_cnt,
  output cpr_pkg::q_head_t            head,
  input  logic                        pop
);

  logic [cpr_pkg::CNT_W-1:0]   cfg_r;
  cpr_pkg::cmd_t               q_mem [cpr_pkg::QUEUE_DEPTH];
  logic [cpr_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cpr_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cpr_pkg::QFILL_W-1:0] fill_r, fill_nxt;
  logic                        push;
  logic                        do_pop;
  cpr_pkg::cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cpr_pkg::CNT_MAX;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign active_cnt = (cfg_r > cpr_pkg::CNT_MAX) ? cpr_pkg::CNT_MAX : cfg_r;

  // decode; out-of-range frame updates become no-ops
  always_comb begin
    cmd.frame = in_data.frame;
    case (in_data.kind)
      cpr_pkg::KIND_VICTIM: cmd.op = cpr_pkg::OP_VICTIM;
      cpr_pkg::KIND_PIN:    cmd.op = cpr_pkg::OP_PIN;
      cpr_pkg::KIND_UNPIN:  cmd.op = cpr_pkg::OP_UNPIN;
      cpr_pkg::KIND_ACCESS: cmd.op = cpr_pkg::OP_ACCESS;
      default:              cmd.op = cpr_pkg::OP_NOP;
    endcase
    if (in_data.kind != cpr_pkg::KIND_VICTIM &&
        {1'b0, in_data.frame} >= active_cnt) begin
      cmd.op = cpr_pkg::OP_NOP;
    end
  end

  assign busy   = (fill_r == cpr_pkg::QFILL_W'(cpr_pkg::QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != '0);

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (fill_r != '0);
  assign head.cmd   = q_mem[rd_ptr_r];

endmodule

### hw/rtl/cpr_back.sv
// Back end: frame marks, clock hand and the victim walk.
module cpr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cpr_pkg::CNT_W-1:0] active_cnt,
  input  cpr_pkg::q_head_t          head,
  output logic                      pop,
  output logic                      out_valid,
  output cpr_pkg::out_item_t        out_data
);

  cpr_pkg::back_state_t                state_r, state_nxt;
  logic [cpr_pkg::FRAME_SLOTS-1:0]     pinned_r, pinned_nxt;
  logic [cpr_pkg::FRAME_SLOTS-1:0]     empty_r, empty_nxt;
  logic [cpr_pkg::FRAME_SLOTS-1:0]     ref_r, ref_nxt;
  logic [cpr_pkg::FRAME_W-1:0]         hand_r, hand_nxt;
  logic [cpr_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic                                out_valid_r, out_valid_nxt;
  cpr_pkg::out_item_t                  out_data_r, out_data_nxt;

  logic [cpr_pkg::CNT_W-1:0]           hand_inc;
  logic [cpr_pkg::FRAME_W-1:0]         hand_adv;
  logic [cpr_pkg::STEP_W-1:0]          step_limit;
  logic                                last_step;
  logic                                skip;
  logic                                second;
  logic                                pick;

  assign hand_inc   = {1'b0, hand_r} + 1'b1;
  assign hand_adv   = (hand_inc >= active_cnt) ? '0 : hand_inc[cpr_pkg::FRAME_W-1:0];
  assign step_limit = {active_cnt, 1'b0};
  assign last_step  = (step_r + 1'b1) == step_limit;
  assign skip       = pinned_r[hand_r] || empty_r[hand_r];
  assign second     = !skip && ref_r[hand_r];
  assign pick       = !skip && !ref_r[hand_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpr_pkg::BK_IDLE: begin
        if (head.valid && head.cmd.op == cpr_pkg::OP_VICTIM && active_cnt != '0) begin
          state_nxt = cpr_pkg::BK_WALK;
        end
      end
      cpr_pkg::BK_WALK: begin
        if (pick || last_step) begin
          state_nxt = cpr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cpr_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop           = 1'b0;
    pinned_nxt    = pinned_r;
    empty_nxt     = empty_r;
    ref_nxt       = ref_r;
    hand_nxt      = hand_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    case (state_r)
      cpr_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          case (head.cmd.op)
            cpr_pkg::OP_VICTIM: begin
              if (active_cnt != '0) begin
                out_valid_nxt = 1'b0;
                step_nxt      = '0;
                if ({1'b0, hand_r} >= active_cnt) begin
                  hand_nxt = '0;
                end
              end
            end
            cpr_pkg::OP_PIN: begin
              pinned_nxt[head.cmd.frame] = 1'b1;
              empty_nxt[head.cmd.frame]  = 1'b0;
            end
            cpr_pkg::OP_UNPIN: begin
              pinned_nxt[head.cmd.frame] = 1'b0;
              empty_nxt[head.cmd.frame]  = 1'b0;
            end
            cpr_pkg::OP_ACCESS: begin
              ref_nxt[head.cmd.frame] = 1'b1;
            end
            default: ;
          endcase
        end
      end
      cpr_pkg::BK_WALK: begin
        hand_nxt = hand_adv;
        step_nxt = step_r + 1'b1;
        if (second) begin
          ref_nxt[hand_r] = 1'b0;
        end
        if (pick) begin
          empty_nxt[hand_r]         = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.found        = 1'b1;
          out_data_nxt.victim_frame = hand_r;
        end else if (last_step) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpr_pkg::BK_IDLE;
      pinned_r    <= '0;
      empty_r     <= '1;
      ref_r       <= '0;
      hand_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pinned_r    <= pinned_nxt;
      empty_r     <= empty_nxt;
      ref_r       <= ref_nxt;
      hand_r      <= hand_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_walk_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cpr_pkg::BK_WALK |-> {1'b0, hand_r} < active_cnt)
    else $error("hand outside active frames during walk");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cpr_pkg::BK_WALK |-> step_r < step_limit)
    else $error("walk ran past its step limit");

  a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.found |-> {1'b0, out_data_r.victim_frame} < active_cnt)
    else $error("victim outside active frames");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.victim_frame == '0)
    else $error("nonzero frame without a victim");

  a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cpr_pkg::BK_WALK |-> !pop)
    else $error("queue popped during walk");

endmodule

### hw/rtl/clock_page_replacer_unit.sv
// Top level of the clock page replacer: front end, command queue and back end.
// Commands transfer on start while busy is low and enter a two-entry queue;
// busy rises only when that queue is full. Every command gives exactly one
// result, shown on out_data for one cycle with out_valid high; the receiver
// cannot stall it. Pin, unpin, access and ignored commands are handled in the
// back end's idle state without a walk. A victim request walks one frame per
// cycle from the clock hand, examining at most twice the active frame count
// (128 at full size); with a zero count it gives a result with found low and
// no walk. The user must write cfg_wdata only while no command is outstanding;
// the block does not enforce this. Values above 64 act as 64.
module clock_page_replacer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  cpr_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output cpr_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [cpr_pkg::CNT_W-1:0] cfg_wdata
);

  logic [cpr_pkg::CNT_W-1:0] active_cnt;
  cpr_pkg::q_head_t          head;
  logic                      pop;

  cpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .active_cnt (active_cnt),
    .head       (head),
    .pop        (pop)
  );

  cpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .active_cnt (active_cnt),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

### test/tb.sv
// Self-checking testbench for clock_page_replacer_unit: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic                      is_cfg;
    logic [cpr_pkg::CNT_W-1:0] cfg_val;
    cpr_pkg::in_item_t         item;
    logic                      fixed;
    cpr_pkg::out_item_t        want;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  cpr_pkg::in_item_t         in_data;
  logic                      out_valid;
  cpr_pkg::out_item_t        out_data;
  logic                      cfg_we;
  logic [cpr_pkg::CNT_W-1:0] cfg_wdata;

  logic               fixed_pending;
  cpr_pkg::out_item_t fixed_value;

  bit                        pin_mark [cpr_pkg::FRAME_SLOTS];
  bit                        empty_mark [cpr_pkg::FRAME_SLOTS];
  bit                        ref_mark [cpr_pkg::FRAME_SLOTS];
  int unsigned               hand_pos;
  logic [cpr_pkg::CNT_W-1:0] frames_cfg;

  cpr_pkg::out_item_t pending_results[$];
  dir_row_t           dir_rows[$];
  int                 errors;
  int                 idle_pct;

  clock_page_replacer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned live_frames();
    return (frames_cfg > cpr_pkg::CNT_MAX) ? cpr_pkg::FRAME_SLOTS : int'(frames_cfg);
  endfunction

  function automatic void clear_frames();
    for (int i = 0; i < cpr_pkg::FRAME_SLOTS; i++) begin
      pin_mark[i] = 1'b0;
      empty_mark[i] = 1'b1;
      ref_mark[i] = 1'b0;
    end
    hand_pos = 0;
    frames_cfg = cpr_pkg::CNT_MAX;
  endfunction

  function automatic cpr_pkg::out_item_t replace_step(cpr_pkg::in_item_t item);
    cpr_pkg::out_item_t res;
    int unsigned        n;
    int unsigned        h;
    int unsigned        i;
    res = '0;
    n = live_frames();
    if (item.kind == cpr_pkg::KIND_VICTIM) begin
      if (n == 0) return res;
      if (hand_pos >= n) hand_pos = 0;
      for (i = 0; i < 2 * n; i++) begin
        h = hand_pos;
        hand_pos = (h + 1 >= n) ? 0 : h + 1;
        if (!pin_mark[h] && !empty_mark[h]) begin
          if (ref_mark[h]) begin
            ref_mark[h] = 1'b0;
          end else begin
            empty_mark[h] = 1'b1;
            res.found = 1'b1;
            res.victim_frame = h[cpr_pkg::FRAME_W-1:0];
            return res;
          end
        end
      end
      return res;
    end
    if (item.frame >= n) return res;
    case (item.kind)
      cpr_pkg::KIND_PIN: begin
        pin_mark[item.frame] = 1'b1;
        empty_mark[item.frame] = 1'b0;
      end
      cpr_pkg::KIND_UNPIN: begin
        pin_mark[item.frame] = 1'b0;
        empty_mark[item.frame] = 1'b0;
      end
      default: begin
        ref_mark[item.frame] = 1'b1;
      end
    endcase
    return res;
  endfunction

  // scoreboard: results first, then config, then new transfers
  always @(posedge clk) begin
    cpr_pkg::out_item_t want;
    cpr_pkg::out_item_t got;
    if (!rst_n) begin
      clear_frames();
      pending_results.delete();
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result found=%0d victim=%0d",
                     out_data.found, out_data.victim_frame);
        end else begin
          want = pending_results.pop_front();
          if (out_data.found !== want.found) begin
            errors++;
            if (errors <= 10)
              $display("found mismatch: expected %0d, got %0d", want.found, out_data.found);
          end
          if (out_data.victim_frame !== want.victim_frame) begin
            errors++;
            if (errors <= 10)
              $display("victim_frame mismatch: expected %0d, got %0d",
                       want.victim_frame, out_data.victim_frame);
          end
        end
      end
      if (cfg_we) frames_cfg = cfg_wdata;
      if (start && !busy) begin
        got = replace_step(in_data);
        pending_results.push_back(fixed_pending ? fixed_value : got);
      end
    end
  end

  function automatic void add_row(bit is_cfg, int val, cpr_pkg::kind_t k, int frame,
                                  bit fixed, bit found, int victim);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.cfg_val = cpr_pkg::CNT_W'(val);
    r.item.kind = k;
    r.item.frame = cpr_pkg::FRAME_W'(frame);
    r.fixed = fixed;
    r.want.found = found;
    r.want.victim_frame = cpr_pkg::FRAME_W'(victim);
    dir_rows.push_back(r);
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_item(cpr_pkg::in_item_t item, bit fixed, cpr_pkg::out_item_t want);
    start <= 1'b1;
    in_data <= item;
    fixed_pending <= fixed;
    fixed_value <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_frames(logic [cpr_pkg::CNT_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                        phase;
    int                        done;
    int                        target;
    int unsigned               n;
    int                        r;
    cpr_pkg::in_item_t         it;
    logic [cpr_pkg::CNT_W-1:0] phase_cfg [6];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    fixed_pending <= 1'b0;
    fixed_value <= '0;
    errors = 0;
    idle_pct = 16;

    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_PIN, 0, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 0, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 1, 1, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 63, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 63, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_ACCESS, 63, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_PIN, 5, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_ACCESS, 5, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 5, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 40, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 2, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(1, 10, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_PIN, 40, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_ACCESS, 63, 1, 0, 0);
    // hand sits past the new count here, walk restarts at frame 0
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(1, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 0, 1, 0, 0);
    add_row(1, 127, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_UNPIN, 63, 1, 0, 0);
    add_row(0, 0, cpr_pkg::KIND_VICTIM, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_frames(dir_rows[i].cfg_val);
      end else begin
        idle_gap();
        send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    phase_cfg[0] = 7'd13;
    phase_cfg[1] = 7'd127;
    phase_cfg[2] = 7'd1;
    phase_cfg[3] = 7'd64;
    phase_cfg[4] = cpr_pkg::CNT_W'($urandom_range(63, 2));
    phase_cfg[5] = 7'd0;
    for (phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 16 : (phase < 4) ? 60 : 0;
      write_frames(phase_cfg[phase]);
      n = (phase_cfg[phase] > cpr_pkg::CNT_MAX) ? cpr_pkg::FRAME_SLOTS :
          int'(phase_cfg[phase]);
      target = (phase == 5) ? 20 : (phase == 3) ? 170 : 120;
      done = 0;
      while (done < target) begin
        r = $urandom_range(99);
        it.kind = (r < 30) ? cpr_pkg::KIND_VICTIM : (r < 60) ? cpr_pkg::KIND_UNPIN :
                  (r < 75) ? cpr_pkg::KIND_PIN : cpr_pkg::KIND_ACCESS;
        if (n > 0 && $urandom_range(9) != 0)
          it.frame = cpr_pkg::FRAME_W'($urandom_range(n - 1));
        else
          it.frame = cpr_pkg::FRAME_W'($urandom_range(63));
        if (it.kind == cpr_pkg::KIND_VICTIM || it.frame < n) done++;
        idle_gap();
        send_item(it, 1'b0, '0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
